// ===== design/llt_pkg.sv =====
package llt_pkg;

    // counter width of position and loop length
    localparam int COUNT_WIDTH = 32;
    localparam int LEN_W       = COUNT_WIDTH - 1;
    localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COUNT_WIDTH - 1);

    // input item fields
    localparam int FUNC_W   = 3;
    localparam int LENGTH_W = 31;
    localparam int SYNC_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd4;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_MEASURE = 2'd1;
    localparam logic [1:0] MODE_PLAY    = 2'd2;

    // configuration port
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 5;

    localparam logic [ADDR_W-1:0]  ADDR_DIV_SHIFT  = 3'd0;
    localparam logic [SHIFT_W-1:0] DIV_SHIFT_RESET = 5'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } llt_cmd_t;

    typedef struct packed {
        logic needs_div;
    } llt_status_t;

endpackage

// ===== design/llt_ctrl.sv =====
module llt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  llt_pkg::llt_status_t status,
    output llt_pkg::llt_cmd_t    cmd
);
    import llt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 accept;
    logic                 out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load     = accept;
    assign cmd.step     = (state_reg == ST_DIV);
    assign cmd.out_load = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.needs_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == DIV_LAST) |=> (state_reg == ST_DONE))
        else $error("remainder loop did not finish after its last step");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.needs_div) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("playing tick did not start the remainder loop");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== design/llt_dp.sv =====
module llt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  llt_pkg::llt_cmd_t                   cmd,
    output llt_pkg::llt_status_t                status,
    input  logic [llt_pkg::SHIFT_W-1:0]         div_shift,
    input  logic [llt_pkg::FUNC_W-1:0]          func,
    input  logic [llt_pkg::LENGTH_W-1:0]        length_value,
    output logic                                sync_valid,
    output logic signed [llt_pkg::SYNC_W-1:0]   sync_pos,
    output logic                                pulse
);
    import llt_pkg::*;

    localparam logic [LEN_W-1:0]              LEN_MAX = {LEN_W{1'b1}};
    localparam logic signed [COUNT_WIDTH-1:0] POS_MAX = {1'b0, {LEN_W{1'b1}}};

    // clock state
    logic [1:0]                      mode_reg;
    logic [1:0]                      mode_next;
    logic [LEN_W-1:0]                len_reg;
    logic [LEN_W-1:0]                len_next;
    logic signed [COUNT_WIDTH-1:0]   pos_reg;
    logic signed [COUNT_WIDTH-1:0]   pos_next;
    logic signed [COUNT_WIDTH-1:0]   start_reg;
    logic signed [COUNT_WIDTH-1:0]   start_next;

    // pending result
    logic                            sv_reg;
    logic                            sv_next;
    logic signed [SYNC_W-1:0]        sp_reg;
    logic signed [SYNC_W-1:0]        sp_next;
    logic                            pend_reg;

    // remainder unit
    logic [COUNT_WIDTH-1:0]          dvd_reg;
    logic [LEN_W-1:0]                div_reg;
    logic [LEN_W-1:0]                rem_reg;
    logic [COUNT_WIDTH-1:0]          rem_sh;
    logic                            rem_ge;
    logic [LEN_W-1:0]                rem_next;

    // output register
    logic                            sync_valid_reg;
    logic signed [SYNC_W-1:0]        sync_pos_reg;
    logic                            pulse_reg;

    logic signed [COUNT_WIDTH-1:0]   pos_inc;
    logic signed [COUNT_WIDTH+1:0]   loop_end;
    logic                            end_hit;
    logic [LEN_W-1:0]                spacing;
    logic [LEN_W-1:0]                spacing_nz;
    logic [63:0]                     lv_wide;
    logic [LEN_W-1:0]                lv_sat;

    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign loop_end = $signed({{2{start_reg[COUNT_WIDTH-1]}}, start_reg})
                    + $signed({3'b000, len_reg});
    assign end_hit  = $signed({{2{pos_inc[COUNT_WIDTH-1]}}, pos_inc}) >= loop_end;

    // a zero spacing pulses on every tick
    assign spacing    = len_reg >> div_shift;
    assign spacing_nz = (spacing == '0) ? LEN_W'(1) : spacing;

    assign lv_wide = 64'(length_value);
    assign lv_sat  = (lv_wide > 64'(LEN_MAX)) ? LEN_MAX : LEN_W'(length_value);

    assign status.needs_div = (func == FUNC_TICK) && (mode_reg == MODE_PLAY);

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        sv_next    = 1'b0;
        sp_next    = '0;
        case (func)
            FUNC_TICK:
            begin
                if (mode_reg == MODE_MEASURE)
                begin
                    if (len_reg != LEN_MAX)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_PLAY)
                begin
                    pos_next = pos_inc;
                    if (end_hit)
                    begin
                        start_next = pos_inc;
                        sv_next    = 1'b1;
                        sp_next    = SYNC_W'(pos_inc);
                    end
                end
            end
            FUNC_START:
            begin
                if (mode_reg == MODE_IDLE && len_reg == '0)
                begin
                    mode_next = MODE_MEASURE;
                end
                else if (len_reg != '0)
                begin
                    pos_next   = '1;
                    start_next = '0;
                    mode_next  = MODE_PLAY;
                    sv_next    = 1'b1;
                    sp_next    = '1;
                end
            end
            FUNC_STOP:
            begin
                mode_next = MODE_IDLE;
            end
            FUNC_RESET:
            begin
                mode_next  = MODE_IDLE;
                len_next   = '0;
                pos_next   = '0;
                start_next = '0;
            end
            FUNC_SET:
            begin
                if (len_reg == '0 && length_value != '0)
                begin
                    len_next = lv_sat;
                    pos_next = '1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // restoring remainder, one dividend bit per step
    assign rem_sh   = {rem_reg, dvd_reg[COUNT_WIDTH-1]};
    assign rem_ge   = rem_sh >= COUNT_WIDTH'(div_reg);
    assign rem_next = rem_ge ? LEN_W'(rem_sh - COUNT_WIDTH'(div_reg)) : LEN_W'(rem_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else if (cmd.load)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sv_reg   <= sv_next;
            sp_reg   <= sp_next;
            pend_reg <= status.needs_div;
            dvd_reg  <= COUNT_WIDTH'(pos_inc);
            div_reg  <= spacing_nz;
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            sync_valid_reg <= sv_reg;
            sync_pos_reg   <= sp_reg;
            pulse_reg      <= pend_reg && (rem_reg == '0);
        end
    end

    assign sync_valid = sync_valid_reg;
    assign sync_pos   = sync_pos_reg;
    assign pulse      = pulse_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (rem_reg < div_reg))
        else $error("remainder not below spacing");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.needs_div) |=> (div_reg != '0))
        else $error("zero spacing loaded into remainder unit");

    a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !sv_reg) |=> (sync_pos == '0 && !sync_valid))
        else $error("sync position not zero without sync");

endmodule

// ===== design/loop_length_tick_clock.sv =====
// event-driven loop clock
// input channel: in_valid/in_stall carry one item (func, length_value); an item
// is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid/out_stall carry one result item per input item
// (sync_valid, sync_pos, pulse), in input order
// a tick while playing runs a bit-serial remainder of the position by the pulse
// spacing, one bit per cycle, before its result is loaded; every other item
// goes from accept straight to the result load
// one item is worked on at a time, so the block takes no new item until the
// result of the last one is in the output register; the next item
// may be taken while the previous result still waits in the output register
// a stalled receiver holds the result in the output register; the block then
// stalls its input once the following item is finished
// reset (rst_n low) idles the clock, clears length, position and loop start,
// and sets div_shift to 2; the apb register div_shift lies at address 0
module loop_length_tick_clock (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [llt_pkg::ADDR_W-1:0]          paddr,
    input  logic [llt_pkg::DATA_W-1:0]          pwdata,
    output logic [llt_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [llt_pkg::FUNC_W-1:0]          func,
    input  logic [llt_pkg::LENGTH_W-1:0]        length_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sync_valid,
    output logic signed [llt_pkg::SYNC_W-1:0]   sync_pos,
    output logic                                pulse
);
    import llt_pkg::*;

    logic [SHIFT_W-1:0] div_shift_reg;
    logic [SHIFT_W-1:0] div_shift_next;
    logic               cfg_write;
    llt_cmd_t           cmd;
    llt_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        div_shift_next = div_shift_reg;
        if (cfg_write && paddr == ADDR_DIV_SHIFT)
        begin
            div_shift_next = pwdata[SHIFT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_DIV_SHIFT: prdata = DATA_W'(div_shift_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_shift_reg <= DIV_SHIFT_RESET;
        end
        else
        begin
            div_shift_reg <= div_shift_next;
        end
    end

    llt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    llt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .div_shift    (div_shift_reg),
        .func         (func),
        .length_value (length_value),
        .sync_valid   (sync_valid),
        .sync_pos     (sync_pos),
        .pulse        (pulse)
    );

endmodule

// ===== tb/loop_length_tick_clock_tb.sv =====
module loop_length_tick_clock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import llt_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [LENGTH_W-1:0] len;
    } loop_item_t;

    typedef struct {
        logic              sync_valid;
        logic [SYNC_W-1:0] sync_pos;
        logic              pulse;
    } loop_result_t;

    localparam longint CNT_MAX     = (longint'(1) << (COUNT_WIDTH - 1)) - 1;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     NUM_PHASES  = 6;
    localparam int     PHASE_ITEMS = 205;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]          pwdata = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [FUNC_W-1:0]          func = FUNC_TICK;
    logic [LENGTH_W-1:0]        length_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       sync_valid;
    logic signed [SYNC_W-1:0]   sync_pos;
    logic                       pulse;

    loop_item_t   item_queue[$];
    loop_result_t result_q[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  sender_calm = 1'b0;
    bit  receiver_calm = 1'b0;

    // clock state as the block should hold it
    logic [1:0]         clk_mode = MODE_IDLE;
    longint             clk_loop_len = 0;
    longint             clk_pos = 0;
    longint             clk_loop_start = 0;
    logic [SHIFT_W-1:0] clk_shift = DIV_SHIFT_RESET;

    loop_length_tick_clock dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .length_value (length_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sync_valid   (sync_valid),
        .sync_pos     (sync_pos),
        .pulse        (pulse)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function loop_result_t predict_loop_event(logic [FUNC_W-1:0] f, logic [LENGTH_W-1:0] len);
        loop_result_t r;
        u64_t         spacing;
        longint       lv;
        r.sync_valid = 1'b0;
        r.sync_pos   = '0;
        r.pulse      = 1'b0;
        lv = longint'(len);
        case (f)
            FUNC_TICK:
            begin
                if (clk_mode == MODE_MEASURE)
                begin
                    if (clk_loop_len < CNT_MAX)
                        clk_loop_len = clk_loop_len + 1;
                end
                else if (clk_mode == MODE_PLAY)
                begin
                    if (clk_pos < CNT_MAX)
                        clk_pos = clk_pos + 1;
                    if (clk_pos >= clk_loop_start + clk_loop_len)
                    begin
                        clk_loop_start = clk_pos;
                        r.sync_valid   = 1'b1;
                        r.sync_pos     = clk_pos[SYNC_W-1:0];
                    end
                    spacing = u64_t'(clk_loop_len) >> clk_shift;
                    // a shifted length of zero pulses on every tick
                    if (spacing == 0)
                        spacing = 1;
                    r.pulse = ((u64_t'(clk_pos) % spacing) == 0);
                end
            end
            FUNC_START:
            begin
                if (clk_mode == MODE_IDLE && clk_loop_len == 0)
                    clk_mode = MODE_MEASURE;
                else if (clk_loop_len != 0)
                begin
                    clk_pos        = -1;
                    clk_loop_start = 0;
                    clk_mode       = MODE_PLAY;
                    r.sync_valid   = 1'b1;
                    r.sync_pos     = '1;
                end
            end
            FUNC_STOP:
                clk_mode = MODE_IDLE;
            FUNC_RESET:
            begin
                clk_mode       = MODE_IDLE;
                clk_loop_len   = 0;
                clk_pos        = 0;
                clk_loop_start = 0;
            end
            FUNC_SET:
            begin
                if (clk_loop_len == 0 && lv > 0)
                begin
                    clk_loop_len = (lv > CNT_MAX) ? CNT_MAX : lv;
                    clk_pos      = -1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function int draw_wait(bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function logic [LENGTH_W-1:0] any_length();
        return LENGTH_W'($urandom());
    endfunction

    task queue_item(logic [FUNC_W-1:0] f, logic [LENGTH_W-1:0] len);
        loop_item_t it;
        it.func = f;
        it.len  = len;
        item_queue.push_back(it);
    endtask

    // mostly complete measure/play or set/play runs, the rest random noise
    task queue_random_items(int n);
        int made;
        int pick;
        int k;
        int m;
        int j;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                k = $urandom_range(0, 12);
                m = $urandom_range(1, 3 * k + 6);
                queue_item(FUNC_RESET, any_length());
                queue_item(FUNC_START, any_length());
                repeat (k) queue_item(FUNC_TICK, any_length());
                queue_item(FUNC_START, any_length());
                repeat (m) queue_item(FUNC_TICK, any_length());
                made += 3 + k + m;
                if ($urandom_range(0, 3) == 0)
                begin
                    j = $urandom_range(1, 8);
                    queue_item(FUNC_STOP, any_length());
                    queue_item(FUNC_START, any_length());
                    repeat (j) queue_item(FUNC_TICK, any_length());
                    made += 2 + j;
                end
            end
            else if (pick < 7)
            begin
                m = $urandom_range(1, 40);
                queue_item(FUNC_RESET, any_length());
                if ($urandom_range(0, 3) == 0)
                    queue_item(FUNC_SET, any_length());
                else
                    queue_item(FUNC_SET, LENGTH_W'($urandom_range(1, 16)));
                queue_item(FUNC_START, any_length());
                repeat (m) queue_item(FUNC_TICK, any_length());
                made += 3 + m;
            end
            else
            begin
                j = $urandom_range(1, 8);
                repeat (j) queue_item(FUNC_W'($urandom_range(0, 7)), any_length());
                made += j;
            end
        end
    endtask

    task write_div_shift(logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DIV_SHIFT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        clk_shift = value[SHIFT_W-1:0];
    endtask

    // sampled at the falling edge so that the driver's updates have settled
    task wait_all_done();
        while (item_queue.size() != 0 || in_valid || result_q.size() != 0)
            @(negedge clk);
    endtask

    // sender: one item per handshake, random gap drawn after each item
    always @(posedge clk)
    begin : drive_items
        loop_item_t   it;
        loop_result_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                res = predict_loop_event(func, length_value);
                result_q.push_back(res);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    it = item_queue.pop_front();
                    func         <= it.func;
                    length_value <= it.len;
                    in_valid     <= 1'b1;
                    gap_left     <= draw_wait(sender_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each result item, then stall for a random while
    always @(posedge clk)
    begin : check_results
        loop_result_t want;
        int           n;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result item with no expected item: sync_valid=%0b sync_pos=%h pulse=%0b",
                           sync_valid, sync_pos, pulse);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (sync_valid !== want.sync_valid)
                    begin
                        $error("sync_valid: expected %0b, actual %0b", want.sync_valid, sync_valid);
                        fail_count++;
                    end
                    if (sync_pos !== want.sync_pos)
                    begin
                        $error("sync_pos: expected %h, actual %h", want.sync_pos, sync_pos);
                        fail_count++;
                    end
                    if (pulse !== want.pulse)
                    begin
                        $error("pulse: expected %0b, actual %0b", want.pulse, pulse);
                        fail_count++;
                    end
                end
                n = draw_wait(receiver_calm);
                stall_left <= n;
                out_stall  <= (n != 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= (stall_left > 1);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("loop_length_tick_clock_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        logic [DATA_W-1:0] value;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset divider
        queue_item(FUNC_START, '0);
        queue_item(FUNC_START, '0);
        repeat (3) queue_item(FUNC_TICK, '0);
        queue_item(FUNC_SET, LENGTH_W'(100));
        queue_item(FUNC_START, '0);
        repeat (4) queue_item(FUNC_TICK, '1);
        queue_item(FUNC_STOP, '0);
        queue_item(FUNC_START, '0);
        queue_item(FUNC_RESET, '0);
        // zero length is ignored, the largest length is taken
        queue_item(FUNC_SET, '0);
        queue_item(FUNC_SET, '1);
        queue_item(FUNC_TICK, '0);
        queue_item(FUNC_START, '0);
        repeat (2) queue_item(FUNC_TICK, '0);
        queue_item(FUNC_RESET, '1);
        queue_item(FUNC_W'(7), '1);
        queue_item(FUNC_SET, LENGTH_W'(1));
        queue_item(FUNC_START, '0);
        repeat (2) queue_item(FUNC_TICK, '0);
        wait_all_done();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: value = 32'd0;
                1: value = 32'd31;
                2: value = 32'd1;
                4: value = 32'd3;
                default: value = $urandom();
            endcase
            write_div_shift(value);
            sender_calm   = (phase == 1 || phase == 3);
            receiver_calm = (phase == 2 || phase == 3);
            queue_random_items(PHASE_ITEMS);
            // the test holds here until every result item has come back
            wait_all_done();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("loop_length_tick_clock_tb: done, clean");
        else
            $display("loop_length_tick_clock_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/llt_pkg.sv
design/llt_ctrl.sv
design/llt_dp.sv
design/loop_length_tick_clock.sv
tb/loop_length_tick_clock_tb.sv
